>>> hdl/bst_pkg.sv
// Shared package for the bounded set table: field widths, command and
// status codes, and the controller/datapath handshake structs.
// No dependencies.
package bst_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W     = 2;
   localparam int VALUE_W   = 32;
   localparam int IDX_OUT_W = 7;
   localparam int STATUS_W  = 2;

   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOCHANGE = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request word, restart scan
      logic scan;    // walk the table one entry per cycle
      logic fetch;   // read the last entry (remove hit)
      logic commit;  // apply the update and load the response register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic need_fetch;
      logic out_free;
   } dp_status_type;

endpackage

>>> hdl/bst_ctrl.sv
// Sequencing state machine for the bounded set table.
// Depends on bst_pkg for the datapath command and status structs.
module bst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bst_pkg::dp_status_type status,
   output bst_pkg::dp_cmd_type    cmd
);
   import bst_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = status.need_fetch ? S_FETCH : S_RESP;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/bst_dpath.sv
// Datapath for the bounded set table: entry memory, count, scan pipeline
// and response register. Depends on bst_pkg.
module bst_dpath #(
   parameter int DEPTH = bst_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bst_pkg::dp_cmd_type               cmd,
   output bst_pkg::dp_status_type            status,
   input  logic [bst_pkg::CMD_W-1:0]         req_command,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_elem_value,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [bst_pkg::IDX_OUT_W-1:0]     rsp_slot_index,
   output logic [bst_pkg::IDX_OUT_W-1:0]     rsp_entry_total,
   output logic [bst_pkg::STATUS_W-1:0]      rsp_status
);
   import bst_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic [VALUE_W-1:0] set_entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_pend_ff, cmp_pend_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [IDX_OUT_W-1:0] rsp_slot_ff, rsp_total_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic               hit_now, scan_issue, rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [CNT_W-1:0]   count_last, count_new, slot_sel;
   logic [STATUS_W-1:0] status_new;

   // compare stage sees the word read in the previous cycle
   assign hit_now    = cmp_pend_ff && (rd_data_ff == value_ff);
   assign scan_issue = cmd.scan && !hit_ff && !hit_now && (rd_idx_ff < count_ff);
   assign count_last = count_ff - CNT_W'(1);

   assign rd_en   = scan_issue || cmd.fetch;
   assign rd_addr = cmd.fetch ? count_last[IDX_W-1:0] : rd_idx_ff[IDX_W-1:0];

   assign status.scan_done  = !cmp_pend_ff && (hit_ff || (rd_idx_ff >= count_ff));
   assign status.need_fetch = hit_ff && (cmd_ff == CMD_REMOVE);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign slot_sel = hit_ff ? slot_ff : count_ff;

   // update decision, applied on commit
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = value_ff;
      count_new  = count_ff;
      status_new = STATUS_DONE;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (hit_ff) begin
               status_new = STATUS_NOCHANGE;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               status_new = STATUS_FULL;
            end else begin
               wr_en     = cmd.commit;
               count_new = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (hit_ff) begin
               // last entry moves into the freed slot
               wr_en     = cmd.commit;
               wr_addr   = slot_ff[IDX_W-1:0];
               wr_data   = rd_data_ff;
               count_new = count_last;
            end else begin
               status_new = STATUS_NOCHANGE;
            end
         end
         default: status_new = STATUS_DONE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd.load ? req_command : cmd_ff;
      value_in     = cmd.load ? req_elem_value : value_ff;
      count_in     = cmd.commit ? count_new : count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_pend_in  = scan_issue;
      cmp_idx_in   = scan_issue ? rd_idx_ff[IDX_W-1:0] : cmp_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         rd_idx_in = '0;
         hit_in    = 1'b0;
      end else if (scan_issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      if (hit_now) begin
         hit_in  = 1'b1;
         slot_in = CNT_W'(cmp_idx_ff);
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         set_entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= set_entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_pend_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_pend_ff  <= cmp_pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      if (cmd.commit) begin
         rsp_found_ff  <= hit_ff;
         rsp_slot_ff   <= IDX_OUT_W'(slot_sel);
         rsp_total_ff  <= IDX_OUT_W'(count_new);
         rsp_status_ff <= status_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> hdl/bounded_set_table.sv
// Top level of the bounded set table: controller plus datapath.
// Depends on bst_pkg, bst_ctrl and bst_dpath.

// A set of up to DEPTH 32-bit values held unordered in a single-port-read
// memory and searched linearly. Each request word carries a command (query,
// insert, remove) and a value; each yields exactly one response word with
// found, slot_index (match slot, or the count when absent), entry_total
// (count after the command) and status (done, full, no change). Insert
// appends after checking for a duplicate; remove copies the last entry into
// the freed slot. One request is processed at a time: req_stall is low only
// while the block is idle. A request scans the entries below the count,
// fetches the last entry when a remove hits, then commits its response;
// the scan reads one entry per cycle through the memory read port. The
// response register lets a new request be taken while the previous
// response still waits under rsp_stall. slot_index and entry_total are 7
// bits wide, exact for DEPTH up to 127. No clearing pass is needed: only
// slots below the count are ever read.
module bounded_set_table #(
   parameter int DEPTH = bst_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bst_pkg::CMD_W-1:0]          req_command,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_elem_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [bst_pkg::IDX_OUT_W-1:0]      rsp_slot_index,
   output logic [bst_pkg::IDX_OUT_W-1:0]      rsp_entry_total,
   output logic [bst_pkg::STATUS_W-1:0]       rsp_status
);
   import bst_pkg::*;

   dp_cmd_type    dp_cmd;     // sequencing commands
   dp_status_type dp_status;  // scan progress, fetch needed, output register free

   bst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   bst_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_command     (req_command),
      .req_elem_value  (req_elem_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status)
   );

`ifndef SYNTHESIS
   // a taken request word keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in flight");

   // a full rejection reports not-found and a full table
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
         (!rsp_found && (rsp_entry_total == IDX_OUT_W'(DEPTH))))
      else $error("full status with inconsistent count or found flag");

   // an absent value with no change leaves the count at the reported slot
   a_nochange_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOCHANGE) && !rsp_found) |->
         (rsp_entry_total == rsp_slot_index))
      else $error("remove miss changed the count");
`endif

endmodule
